@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent implies the consequent at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bsc_pkg.sv @@
package bsc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_B1_B2 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MC_MD = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OSS = 3'd5;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] B4_OFFSET = 32'd32768;
  localparam logic [31:0] B7_SCALE = 32'd50000;
  localparam logic [31:0] P_C1 = 32'd3038;
  localparam logic [31:0] P_C2 = 32'hFFFF_E343;
  localparam logic [31:0] P_C3 = 32'd3791;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] full;
    full = a * b;
    return full[31:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

@@ rtl/bsc_div_pipe.sv @@
module bsc_div_pipe #(
  parameter int unsigned Width = 32,
  parameter int unsigned SideW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  input  logic [SideW-1:0] side,
  output logic             out_v,
  output logic [Width-1:0] quotient,
  output logic [SideW-1:0] side_out
);

  logic             v   [Width];
  logic [Width-1:0] rem [Width];
  logic [Width-1:0] quo [Width];
  logic [Width-1:0] dvd [Width];
  logic [Width-1:0] dsr [Width];
  logic [SideW-1:0] sd  [Width];

  for (genvar i = 0; i < Width; i++) begin : g_stage
    logic             pv;
    logic [Width-1:0] prem, pquo, pdvd, pdsr;
    logic [SideW-1:0] psd;
    logic [Width:0]   trial;
    logic             fits;

    if (i == 0) begin : g_first
      assign pv = in_v;
      assign prem = '0;
      assign pquo = '0;
      assign pdvd = dividend;
      assign pdsr = divisor;
      assign psd = side;
    end else begin : g_rest
      assign pv = v[i-1];
      assign prem = rem[i-1];
      assign pquo = quo[i-1];
      assign pdvd = dvd[i-1];
      assign pdsr = dsr[i-1];
      assign psd = sd[i-1];
    end

    assign trial = {prem, pdvd[Width-1]};
    assign fits = trial >= {1'b0, pdsr};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= fits ? Width'(trial - {1'b0, pdsr}) : trial[Width-1:0];
        quo[i] <= {pquo[Width-2:0], fits};
        dvd[i] <= {pdvd[Width-2:0], 1'b0};
        dsr[i] <= pdsr;
        sd[i] <= psd;
      end
    end
  end

  assign out_v = v[Width-1];
  assign quotient = quo[Width-1];
  assign side_out = sd[Width-1];

endmodule

@@ rtl/barometric_sensor_compensation_unit.sv @@
// Pressure and temperature compensation for a digital barometer.
// Input channel: raw_temperature and raw_pressure with in_valid; the block
// raises in_stall to hold off new requests. Output channel: temperature,
// pressure and divide_error with out_valid; the receiver raises out_stall.
// Calibration words and the oversampling setting are written through the
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data); the user must
// write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high and unknown indexes are ignored. A request
// passes 12 arithmetic stages plus two 32-stage divider pipelines, one
// quotient bit per stage, at one request per cycle when not stalled.
// When the receiver stalls a valid result, the whole pipeline freezes and
// in_stall is high in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits and the calibration registers.
// A zero divisor gives divide_error high with both results zero.
`include "assert_macros.svh"

module barometric_sensor_compensation_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [15:0]                  raw_temperature,
  input  logic [23:0]                  raw_pressure,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           temperature,
  output logic signed [31:0]           pressure,
  output logic                         divide_error,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]                  cfg_data
);

  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;
  logic        en;

  assign cfg_ready = 1'b1;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2 <= '0;
      mc_md <= '0;
      oss <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsc_pkg::CFG_AC1_AC2: ac1_ac2 <= cfg_data;
        bsc_pkg::CFG_AC3_AC4: ac3_ac4 <= cfg_data;
        bsc_pkg::CFG_AC5_AC6: ac5_ac6 <= cfg_data;
        bsc_pkg::CFG_B1_B2: b1_b2 <= cfg_data;
        bsc_pkg::CFG_MC_MD: mc_md <= cfg_data;
        bsc_pkg::CFG_OSS: oss <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bsc_pkg::sx16(ac1_ac2[31:16]);
  assign ac2 = bsc_pkg::sx16(ac1_ac2[15:0]);
  assign ac3 = bsc_pkg::sx16(ac3_ac4[31:16]);
  assign ac4 = {16'd0, ac3_ac4[15:0]};
  assign ac5 = {16'd0, ac5_ac6[31:16]};
  assign ac6 = {16'd0, ac5_ac6[15:0]};
  assign b1 = bsc_pkg::sx16(b1_b2[31:16]);
  assign b2 = bsc_pkg::sx16(b1_b2[15:0]);
  assign mc = bsc_pkg::sx16(mc_md[31:16]);
  assign md = bsc_pkg::sx16(mc_md[15:0]);

  logic        s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v, s8_v, s9_v, s10_v, s11_v;
  logic [31:0] s1_prod;
  logic [23:0] s1_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= bsc_pkg::mul32({16'd0, raw_temperature} - ac6, ac5);
      s1_up <= raw_pressure >> (4'd8 - {2'd0, oss});
    end
  end

  logic [31:0] x1a, den, num;
  logic [31:0] s2_x1, s2_na, s2_da;
  logic [23:0] s2_up;
  logic        s2_err, s2_neg;

  assign x1a = bsc_pkg::asr(s1_prod, 15);
  assign den = x1a + md;
  assign num = mc << 11;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1 <= x1a;
      s2_up <= s1_up;
      s2_err <= den == 32'd0;
      s2_neg <= num[31] ^ den[31];
      s2_na <= num[31] ? 32'd0 - num : num;
      s2_da <= den[31] ? 32'd0 - den : den;
    end
  end

  localparam int unsigned Side1W = 32 + 24 + 2;
  logic              d1_v;
  logic [31:0]       d1_q;
  logic [Side1W-1:0] d1_side;

  bsc_div_pipe #(.Width(bsc_pkg::DataW), .SideW(Side1W)) u_div_temp (
    .clk(clk), .rst(rst), .en(en), .in_v(s2_v),
    .dividend(s2_na), .divisor(s2_da),
    .side({s2_x1, s2_up, s2_err, s2_neg}),
    .out_v(d1_v), .quotient(d1_q), .side_out(d1_side)
  );

  logic [31:0] d1_x1, x2a, b5;
  logic [23:0] d1_up;
  logic [31:0] s3_t, s3_b6;
  logic [23:0] s3_up;
  logic        s3_err;

  assign d1_x1 = d1_side[Side1W-1 -: 32];
  assign d1_up = d1_side[25:2];
  assign x2a = d1_side[0] ? 32'd0 - d1_q : d1_q;
  assign b5 = d1_x1 + x2a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t <= bsc_pkg::asr(b5 + 32'd8, 4);
      s3_b6 <= b5 - bsc_pkg::B6_OFFSET;
      s3_up <= d1_up;
      s3_err <= d1_side[1];
    end
  end

  logic [31:0] s4_sq, s4_m2, s4_m3, s4_t;
  logic [23:0] s4_up;
  logic        s4_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sq <= bsc_pkg::asr(bsc_pkg::mul32(s3_b6, s3_b6), 12);
      s4_m2 <= bsc_pkg::mul32(ac2, s3_b6);
      s4_m3 <= bsc_pkg::mul32(ac3, s3_b6);
      s4_t <= s3_t;
      s4_up <= s3_up;
      s4_err <= s3_err;
    end
  end

  logic [31:0] s5_x1, s5_x2, s5_x1b, s5_x2b, s5_t;
  logic [23:0] s5_up;
  logic        s5_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_x1 <= bsc_pkg::asr(bsc_pkg::mul32(b2, s4_sq), 11);
      s5_x2 <= bsc_pkg::asr(s4_m2, 11);
      s5_x1b <= bsc_pkg::asr(s4_m3, 13);
      s5_x2b <= bsc_pkg::asr(bsc_pkg::mul32(b1, s4_sq), 16);
      s5_t <= s4_t;
      s5_up <= s4_up;
      s5_err <= s4_err;
    end
  end

  logic [31:0] x3a, b3pre;
  logic [31:0] s6_b3, s6_x3b, s6_t;
  logic [23:0] s6_up;
  logic        s6_err;

  assign x3a = s5_x1 + s5_x2;
  assign b3pre = ((ac1 << 2) + x3a) << oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_b3 <= bsc_pkg::asr(b3pre + 32'd2, 2);
      s6_x3b <= bsc_pkg::asr(s5_x1b + s5_x2b + 32'd2, 2);
      s6_t <= s5_t;
      s6_up <= s5_up;
      s6_err <= s5_err;
    end
  end

  logic [31:0] s7_b4, s7_d, s7_t;
  logic        s7_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_b4 <= bsc_pkg::mul32(ac4, s6_x3b + bsc_pkg::B4_OFFSET) >> 15;
      s7_d <= {8'd0, s6_up} - s6_b3;
      s7_t <= s6_t;
      s7_err <= s6_err;
    end
  end

  logic [31:0] b7;
  logic [31:0] s8_dvd, s8_b4, s8_t;
  logic        s8_err, s8_hi;

  assign b7 = bsc_pkg::mul32(s7_d, bsc_pkg::B7_SCALE >> oss);

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_dvd <= b7[31] ? b7 : {b7[30:0], 1'b0};
      s8_hi <= b7[31];
      s8_b4 <= s7_b4;
      s8_t <= s7_t;
      s8_err <= s7_err || (s7_b4 == 32'd0);
    end
  end

  localparam int unsigned Side2W = 32 + 2;
  logic              d2_v;
  logic [31:0]       d2_q;
  logic [Side2W-1:0] d2_side;

  bsc_div_pipe #(.Width(bsc_pkg::DataW), .SideW(Side2W)) u_div_pres (
    .clk(clk), .rst(rst), .en(en), .in_v(s8_v),
    .dividend(s8_dvd), .divisor(s8_b4),
    .side({s8_t, s8_err, s8_hi}),
    .out_v(d2_v), .quotient(d2_q), .side_out(d2_side)
  );

  logic [31:0] s9_p, s9_t;
  logic        s9_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_p <= d2_side[0] ? {d2_q[30:0], 1'b0} : d2_q;
      s9_t <= d2_side[Side2W-1 -: 32];
      s9_err <= d2_side[1];
    end
  end

  logic [31:0] pa;
  logic [31:0] s10_x1, s10_x2, s10_p, s10_t;
  logic        s10_err;

  assign pa = bsc_pkg::asr(s9_p, 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_x1 <= bsc_pkg::mul32(pa, pa);
      s10_x2 <= bsc_pkg::mul32(bsc_pkg::P_C2, s9_p);
      s10_p <= s9_p;
      s10_t <= s9_t;
      s10_err <= s9_err;
    end
  end

  logic [31:0] s11_x1, s11_x2, s11_p, s11_t;
  logic        s11_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (en) begin
      s11_v <= s10_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_x1 <= bsc_pkg::asr(bsc_pkg::mul32(s10_x1, bsc_pkg::P_C1), 16);
      s11_x2 <= bsc_pkg::asr(s10_x2, 16);
      s11_p <= s10_p;
      s11_t <= s10_t;
      s11_err <= s10_err;
    end
  end

  logic [31:0] pfin;
  assign pfin = s11_p + bsc_pkg::asr(s11_x1 + s11_x2 + bsc_pkg::P_C3, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s11_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature <= s11_err ? 32'sd0 : $signed(s11_t);
      pressure <= s11_err ? 32'sd0 : $signed(pfin);
      divide_error <= s11_err;
    end
  end

  `ASSERT_ALWAYS(a_stall_backpressure, clk, rst, !(out_valid && out_stall) || in_stall, "stalled output must stall the input")
  `ASSERT_ALWAYS(a_error_zero, clk, rst, !(out_valid && divide_error) || (temperature == 32'sd0 && pressure == 32'sd0), "error result must be zero")
  `ASSERT_NEXT(a_accept_enters, clk, rst, in_valid && !in_stall, s1_v, "accepted request must enter the first stage")

endmodule
